FILE: design/klp_pkg.sv
// ---------------------------------------------------------------------------
// klp_pkg
// Shared types, constants and character classifiers for the key list block.
// ---------------------------------------------------------------------------
package klp_pkg;

  localparam int KEY_BYTES_DEF         = 32;
  localparam int ALIAS_BYTES_DEF       = 12;
  localparam int ALIAS_ASCII_BYTES_DEF = 3;
  localparam int MAX_KEYS_DEF          = 16;

  localparam logic [10:0] CHAR_TOTAL_MAX = 11'd2047;
  localparam logic [7:0]  CH_COLON = 8'h3A;
  localparam logic [7:0]  CH_SLASH = 8'h2F;
  localparam logic [7:0]  CH_EQUAL = 8'h3D;
  localparam logic [7:0]  CH_PLUS  = 8'h2B;

  typedef enum logic [1:0] {
    KIND_CHAR   = 2'd0,
    KIND_END    = 2'd1,
    KIND_LOOKUP = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_ACCEPTED  = 2'd0,
    ST_SYNTAX    = 2'd1,
    ST_KEY_WORD  = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_READ,
    BK_EMIT
  } bk_state_t;

  // Queue entry from front to back.
  typedef struct packed {
    logic        is_end;
    logic [1:0]  end_status;
    logic [4:0]  end_count;
    logic [31:0] alias_high;
    logic [63:0] alias_low;
  } cmd_t;

  // Table-clear and count-publish signals from front to back.
  typedef struct packed {
    logic       clear;
    logic       publish;
    logic [4:0] count;
  } tbl_ctl_t;

  function automatic logic [6:0] b64_val(input logic [7:0] c);
    logic [6:0] v;
    v = 7'h40;
    if (c >= 8'h41 && c <= 8'h5A) v = {1'b0, 6'(c - 8'h41)};
    else if (c >= 8'h61 && c <= 8'h7A) v = {1'b0, 6'(c - 8'h61 + 8'd26)};
    else if (c >= 8'h30 && c <= 8'h39) v = {1'b0, 6'(c - 8'h30 + 8'd52)};
    else if (c == CH_PLUS) v = 7'd62;
    else if (c == CH_SLASH) v = 7'd63;
    return v;
  endfunction

  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] v;
    v = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) v = {1'b0, 4'(c - 8'h30)};
    else if (c >= 8'h61 && c <= 8'h66) v = {1'b0, 4'(c - 8'h61 + 8'd10)};
    else if (c >= 8'h41 && c <= 8'h46) v = {1'b0, 4'(c - 8'h41 + 8'd10)};
    return v;
  endfunction

endpackage

FILE: design/klp_in_if.sv
// ---------------------------------------------------------------------------
// klp_in_if
// Input channel: valid/ready with item payload.
// ---------------------------------------------------------------------------
interface klp_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  list_char;
  logic [31:0] alias_high;
  logic [63:0] alias_low;
  modport source (output valid, kind, list_char, alias_high, alias_low, input ready);
  modport sink   (input valid, kind, list_char, alias_high, alias_low, output ready);
endinterface

FILE: design/klp_out_if.sv
// ---------------------------------------------------------------------------
// klp_out_if
// Result channel: valid/ready with result payload.
// ---------------------------------------------------------------------------
interface klp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [4:0]  key_count;
  logic [63:0] key_word;
  logic        last;
  modport source (output valid, status, key_count, key_word, last, input ready);
  modport sink   (input valid, status, key_count, key_word, last, output ready);
endinterface

FILE: design/key_list_parser_and_lookup_top.sv
// ---------------------------------------------------------------------------
// key_list_parser_and_lookup_top
// Key list parser with alias-to-key lookup table.
// ---------------------------------------------------------------------------
// List characters and lookups are taken one per cycle; lookups stall only
// when the two-entry command queue is full. The first character of a list
// and the end item wait until every earlier lookup has left the queue and
// the lookup engine is idle, so the table never changes under a lookup. An
// end item gives one result. A lookup walks the alias table one entry at a
// time through the registered alias RAM read and, on the first match, sends
// the key out as 64-bit key words; a miss gives one not-found result once
// every stored entry has been tried. Results leave through a single output
// register.
module key_list_parser_and_lookup_top #(
  parameter int KEY_BYTES         = klp_pkg::KEY_BYTES_DEF,
  parameter int ALIAS_BYTES       = klp_pkg::ALIAS_BYTES_DEF,
  parameter int ALIAS_ASCII_BYTES = klp_pkg::ALIAS_ASCII_BYTES_DEF,
  parameter int MAX_KEYS          = klp_pkg::MAX_KEYS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  klp_in_if.sink     in_ch,
  klp_out_if.source  out_ch
);
  import klp_pkg::*;

  cmd_t        q_wdata, q_rdata;
  tbl_ctl_t    tbl;
  logic        q_push, q_pop, q_full, q_empty;
  logic        back_idle, drained;
  logic        key_we, al_we;
  logic [5:0]  key_waddr, key_raddr;
  logic [63:0] key_wdata, key_rdata;
  logic [3:0]  al_waddr, al_raddr;
  logic [95:0] al_wdata, al_rdata;

  assign drained = q_empty && back_idle;

  klp_front #(
    .KEY_BYTES(KEY_BYTES), .ALIAS_BYTES(ALIAS_BYTES),
    .ALIAS_ASCII_BYTES(ALIAS_ASCII_BYTES), .MAX_KEYS(MAX_KEYS)
  ) u_front (
    .clk, .rst_n, .in_ch, .q_full, .drained, .q_push, .q_data(q_wdata), .tbl,
    .key_we, .key_waddr, .key_wdata, .al_we, .al_waddr, .al_wdata
  );

  klp_queue u_queue (
    .clk, .rst_n, .push(q_push), .wdata(q_wdata), .full(q_full),
    .pop(q_pop), .empty(q_empty), .rdata(q_rdata)
  );

  klp_ram #(.WIDTH(64), .DEPTH(64)) u_key_ram (
    .clk, .we(key_we), .waddr(key_waddr), .wdata(key_wdata),
    .raddr(key_raddr), .rdata(key_rdata)
  );

  klp_ram #(.WIDTH(96), .DEPTH(16)) u_alias_ram (
    .clk, .we(al_we), .waddr(al_waddr), .wdata(al_wdata),
    .raddr(al_raddr), .rdata(al_rdata)
  );

  klp_back #(
    .KEY_BYTES(KEY_BYTES), .ALIAS_BYTES(ALIAS_BYTES), .MAX_KEYS(MAX_KEYS)
  ) u_back (
    .clk, .rst_n, .tbl, .q_empty, .q_data(q_rdata), .q_pop, .idle(back_idle),
    .al_raddr, .al_rdata, .key_raddr, .key_rdata, .out_ch
  );
endmodule

FILE: design/klp_ram.sv
// ---------------------------------------------------------------------------
// klp_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module klp_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

FILE: design/klp_front.sv
// ---------------------------------------------------------------------------
// klp_front
// Character parser: checks record structure, decodes base64 key and alias
// bytes into the stores, and turns end/lookup items into queue commands.
// ---------------------------------------------------------------------------
module klp_front #(
  parameter int KEY_BYTES         = klp_pkg::KEY_BYTES_DEF,
  parameter int ALIAS_BYTES       = klp_pkg::ALIAS_BYTES_DEF,
  parameter int ALIAS_ASCII_BYTES = klp_pkg::ALIAS_ASCII_BYTES_DEF,
  parameter int MAX_KEYS          = klp_pkg::MAX_KEYS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  klp_in_if.sink             in_ch,
  input  logic               q_full,
  input  logic               drained,
  output logic               q_push,
  output klp_pkg::cmd_t      q_data,
  output klp_pkg::tbl_ctl_t  tbl,
  output logic               key_we,
  output logic [5:0]         key_waddr,
  output logic [63:0]        key_wdata,
  output logic               al_we,
  output logic [3:0]         al_waddr,
  output logic [95:0]        al_wdata
);
  import klp_pkg::*;

  localparam int KEY_CHARS   = (KEY_BYTES * 8 + 5) / 6;
  localparam int KEY_FIELD   = (KEY_CHARS + 3) / 4 * 4;
  localparam int ALIAS_FIELD = ALIAS_ASCII_BYTES + (ALIAS_BYTES - ALIAS_ASCII_BYTES) * 2;
  localparam int RECORD_LEN  = KEY_FIELD + 1 + ALIAS_FIELD;

  logic [4:0]  rec_r, rec_nxt;
  logic [10:0] total_r, total_nxt;
  logic [6:0]  pos_r, pos_nxt;
  logic [11:0] bits_r, bits_nxt;
  logic [63:0] word_r, word_nxt;
  logic        err_r, err_nxt;
  logic [95:0] alias_r, alias_nxt;
  logic [4:0]  byte_r, byte_nxt;   // next key byte index
  logic [3:0]  hold_r, hold_nxt;   // bits held in bit buffer after decode

  logic        acc;
  logic        need_drain;
  logic [1:0]  kind;
  logic [7:0]  c;
  logic [6:0]  bv;
  logic [4:0]  hv;
  logic [6:0]  q;
  logic [6:0]  h;
  logic [6:0]  aj;
  logic [11:0] nb;
  logic [3:0]  held;
  logic [7:0]  kbyte;
  logic        put_alias;
  logic [7:0]  abyte;

  assign kind = in_ch.kind;
  assign c    = in_ch.list_char;
  assign bv   = b64_val(c);
  assign hv   = hex_val(c);
  assign q    = pos_r - 7'(KEY_FIELD + 1);
  assign h    = q - 7'(ALIAS_ASCII_BYTES);

  // Commands need queue space; characters never stall, except that the first
  // character of a list and the end item hold until earlier lookups are done.
  assign need_drain  = (kind == KIND_END) || (kind == KIND_CHAR && total_r == '0);
  assign in_ch.ready = (kind == KIND_CHAR || !q_full) && (!need_drain || drained);
  assign acc = in_ch.valid && in_ch.ready;

  always_comb begin
    rec_nxt   = rec_r;
    total_nxt = total_r;
    pos_nxt   = pos_r;
    bits_nxt  = bits_r;
    word_nxt  = word_r;
    err_nxt   = err_r;
    alias_nxt = alias_r;
    byte_nxt  = byte_r;
    hold_nxt  = hold_r;
    q_push    = 1'b0;
    q_data    = '0;
    tbl       = '0;
    key_we    = 1'b0;
    key_waddr = '0;
    key_wdata = word_r;
    al_we     = 1'b0;
    al_waddr  = rec_r[3:0];
    al_wdata  = alias_r;
    nb        = '0;
    held      = '0;
    kbyte     = '0;
    put_alias = 1'b0;
    abyte     = '0;
    aj        = '0;
    if (acc) begin
      unique case (kind_t'(kind))
        KIND_CHAR: begin
          if (total_r == '0) tbl.clear = 1'b1;
          if (total_r != CHAR_TOTAL_MAX) total_nxt = total_r + 11'd1;
          if (!err_r) begin
            if (pos_r >= 7'(RECORD_LEN)) begin
              if (c == CH_SLASH) pos_nxt = '0;
              else err_nxt = 1'b1;
            end else if (pos_r == '0 && rec_r >= 5'(MAX_KEYS)) begin
              err_nxt = 1'b1;
            end else if (pos_r < 7'(KEY_CHARS)) begin
              if (bv[6]) err_nxt = 1'b1;
              else begin
                nb = (pos_r == '0) ? {6'd0, bv[5:0]} : {bits_r[5:0], bv[5:0]};
                held = (pos_r == '0) ? 4'd6 : hold_r + 4'd6;
                bits_nxt = nb;
                word_nxt = (pos_r == '0) ? '0 : word_r;
                byte_nxt = (pos_r == '0) ? '0 : byte_r;
                if (held >= 4'd8) begin
                  kbyte = 8'(nb >> (held - 4'd8));
                  held  = held - 4'd8;
                  if (byte_nxt < 5'(KEY_BYTES - 1) || KEY_BYTES == 32 ||
                      byte_nxt == 5'(KEY_BYTES - 1)) begin
                    word_nxt = word_nxt |
                               (64'(kbyte) << (6'd56 - {byte_nxt[2:0], 3'b000}));
                    if (byte_nxt[2:0] == 3'd7 || byte_nxt == 5'(KEY_BYTES - 1)) begin
                      key_we    = 1'b1;
                      key_waddr = {rec_r[3:0], byte_nxt[4:3]};
                      key_wdata = word_nxt;
                      word_nxt  = '0;
                    end
                  end
                  byte_nxt = byte_nxt + 5'd1;
                end
                hold_nxt = held;
              end
            end else if (pos_r < 7'(KEY_FIELD)) begin
              if (c != CH_EQUAL) err_nxt = 1'b1;
            end else if (pos_r == 7'(KEY_FIELD)) begin
              if (c != CH_COLON) err_nxt = 1'b1;
              else alias_nxt = '0;
            end else if (q < 7'(ALIAS_ASCII_BYTES)) begin
              if (c < 8'h20 || c > 8'h7E) err_nxt = 1'b1;
              else begin
                put_alias = 1'b1;
                abyte     = c;
                aj        = q;
              end
            end else begin
              if (hv[4]) err_nxt = 1'b1;
              else if (!h[0]) bits_nxt = {8'd0, hv[3:0]};
              else begin
                put_alias = 1'b1;
                abyte     = {bits_r[3:0], hv[3:0]};
                aj        = 7'(ALIAS_ASCII_BYTES) + (h >> 1);
              end
            end
            if (put_alias && aj < 7'(ALIAS_BYTES))
              alias_nxt[7'd95 - {aj[3:0], 3'b000} -: 8] = abyte;
            if (err_nxt == 1'b0 && pos_r < 7'(RECORD_LEN) &&
                !(pos_r == '0 && rec_r >= 5'(MAX_KEYS))) begin
              pos_nxt = pos_r + 7'd1;
              if (pos_r + 7'd1 == 7'(RECORD_LEN)) begin
                rec_nxt  = rec_r + 5'd1;
                al_we    = 1'b1;
                al_wdata = alias_nxt;
              end
            end
          end
        end
        KIND_END: begin
          q_push = 1'b1;
          q_data.is_end = 1'b1;
          if (total_r < 11'(RECORD_LEN)) begin
            q_data.end_status = ST_ACCEPTED;
            q_data.end_count  = '0;
          end else if (err_r || pos_r != 7'(RECORD_LEN)) begin
            q_data.end_status = ST_SYNTAX;
            q_data.end_count  = '0;
          end else begin
            q_data.end_status = ST_ACCEPTED;
            q_data.end_count  = rec_r;
          end
          tbl.publish = 1'b1;
          tbl.count   = q_data.end_count;
          rec_nxt   = '0;
          total_nxt = '0;
          pos_nxt   = '0;
          bits_nxt  = '0;
          word_nxt  = '0;
          err_nxt   = 1'b0;
        end
        KIND_LOOKUP: begin
          q_push = 1'b1;
          q_data.alias_high = in_ch.alias_high;
          q_data.alias_low  = in_ch.alias_low;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_r   <= '0;
      total_r <= '0;
      pos_r   <= '0;
      bits_r  <= '0;
      word_r  <= '0;
      err_r   <= 1'b0;
      byte_r  <= '0;
      hold_r  <= '0;
    end else begin
      rec_r   <= rec_nxt;
      total_r <= total_nxt;
      pos_r   <= pos_nxt;
      bits_r  <= bits_nxt;
      word_r  <= word_nxt;
      err_r   <= err_nxt;
      byte_r  <= byte_nxt;
      hold_r  <= hold_nxt;
    end
  end

  always_ff @(posedge clk) alias_r <= alias_nxt;
endmodule

FILE: design/klp_queue.sv
// ---------------------------------------------------------------------------
// klp_queue
// Two-entry command queue between parser and lookup engine.
// ---------------------------------------------------------------------------
module klp_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  klp_pkg::cmd_t wdata,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output klp_pkg::cmd_t rdata
);
  import klp_pkg::*;

  cmd_t       slot_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full  = cnt_r == 2'd2;
  assign empty = cnt_r == 2'd0;
  assign rdata = slot_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r ^ push;
    rp_nxt  = rp_r ^ pop;
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) if (push) slot_r[wp_r] <= wdata;
endmodule

FILE: design/klp_back.sv
// ---------------------------------------------------------------------------
// klp_back
// Command executor: reports list ends and walks the alias table for lookups,
// streaming the matching key words out through a result register.
// ---------------------------------------------------------------------------
module klp_back #(
  parameter int KEY_BYTES   = klp_pkg::KEY_BYTES_DEF,
  parameter int ALIAS_BYTES = klp_pkg::ALIAS_BYTES_DEF,
  parameter int MAX_KEYS    = klp_pkg::MAX_KEYS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  klp_pkg::tbl_ctl_t tbl,
  input  logic              q_empty,
  input  klp_pkg::cmd_t     q_data,
  output logic              q_pop,
  output logic              idle,
  output logic [3:0]        al_raddr,
  input  logic [95:0]       al_rdata,
  output logic [5:0]        key_raddr,
  input  logic [63:0]       key_rdata,
  klp_out_if.source         out_ch
);
  import klp_pkg::*;

  localparam int KEY_WORDS = (KEY_BYTES + 7) / 8;

  bk_state_t   st_r, st_nxt;
  logic [4:0]  count_r, count_nxt;
  logic [4:0]  idx_r, idx_nxt;
  logic [1:0]  w_r, w_nxt;
  logic        ov_r, ov_nxt;
  logic [1:0]  os_r, os_nxt;
  logic [4:0]  oc_r, oc_nxt;
  logic [63:0] ow_r, ow_nxt;
  logic        ol_r, ol_nxt;
  logic [95:0] mask;
  logic        hit;
  logic        out_free;

  always_comb begin
    mask = '0;
    for (int j = 0; j < 12; j++)
      if (j < ALIAS_BYTES) mask[95 - 8*j -: 8] = 8'hFF;
  end

  assign hit      = ((al_rdata ^ {q_data.alias_high, q_data.alias_low}) & mask) == '0;
  assign out_free = !ov_r || out_ch.ready;
  assign idle     = (st_r == BK_IDLE);
  assign al_raddr = idx_r[3:0];
  assign key_raddr = {idx_r[3:0], w_r};

  assign out_ch.valid     = ov_r;
  assign out_ch.status    = os_r;
  assign out_ch.key_count = oc_r;
  assign out_ch.key_word  = ow_r;
  assign out_ch.last      = ol_r;

  always_comb begin
    st_nxt    = st_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    w_nxt     = w_r;
    q_pop     = 1'b0;
    ov_nxt    = ov_r && !out_ch.ready;
    os_nxt    = os_r;
    oc_nxt    = oc_r;
    ow_nxt    = ow_r;
    ol_nxt    = ol_r;
    if (tbl.clear) count_nxt = '0;
    if (tbl.publish) count_nxt = tbl.count;
    unique case (st_r)
      BK_IDLE: begin
        if (!q_empty && out_free) begin
          if (q_data.is_end) begin
            q_pop  = 1'b1;
            ov_nxt = 1'b1;
            os_nxt = q_data.end_status;
            oc_nxt = q_data.end_count;
            ow_nxt = '0;
            ol_nxt = 1'b1;
          end else begin
            idx_nxt = '0;
            w_nxt   = '0;
            st_nxt  = BK_SCAN;
          end
        end
      end
      BK_SCAN: begin
        // Registered alias read for idx_r lands next cycle.
        if (idx_r >= count_r || idx_r >= 5'(MAX_KEYS)) begin
          if (out_free) begin
            q_pop  = 1'b1;
            ov_nxt = 1'b1;
            os_nxt = ST_NOT_FOUND;
            oc_nxt = '0;
            ow_nxt = '0;
            ol_nxt = 1'b1;
            st_nxt = BK_IDLE;
          end
        end else begin
          st_nxt = BK_READ;
        end
      end
      BK_READ: begin
        if (hit) st_nxt = BK_EMIT;
        else begin
          idx_nxt = idx_r + 5'd1;
          st_nxt  = BK_SCAN;
        end
      end
      BK_EMIT: begin
        // key_rdata holds word w_r, read from the address set up in BK_READ.
        if (out_free) begin
          ov_nxt = 1'b1;
          os_nxt = ST_KEY_WORD;
          oc_nxt = '0;
          ow_nxt = key_rdata;
          ol_nxt = (w_r == 2'(KEY_WORDS - 1));
          if (w_r == 2'(KEY_WORDS - 1)) begin
            q_pop  = 1'b1;
            st_nxt = BK_IDLE;
          end else begin
            w_nxt  = w_r + 2'd1;
            st_nxt = BK_READ;
          end
        end
      end
      default: st_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= BK_IDLE;
      count_r <= '0;
      idx_r   <= '0;
      w_r     <= '0;
      ov_r    <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
      w_r     <= w_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    os_r <= os_nxt;
    oc_r <= oc_nxt;
    ow_r <= ow_nxt;
    ol_r <= ol_nxt;
  end
endmodule

FILE: design/klp_checker.sv
// ---------------------------------------------------------------------------
// klp_checker
// Port-level checks on the result channel.
// ---------------------------------------------------------------------------
module klp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [4:0]  out_key_count,
  input logic [63:0] out_key_word,
  input logic        out_last
);
  import klp_pkg::*;

  // Hold a stalled beat.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_key_word))
    else $error("stalled result changed");

  a_not_found_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_NOT_FOUND |-> out_last && out_key_word == '0)
    else $error("not-found beat malformed");

  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_ACCEPTED || out_status == ST_SYNTAX) |-> out_last)
    else $error("end beat not last");

  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_ACCEPTED |-> out_key_count == '0)
    else $error("key count on non-accept beat");
endmodule

bind key_list_parser_and_lookup_top klp_checker u_klp_checker (
  .clk(clk), .rst_n(rst_n), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_status(out_ch.status), .out_key_count(out_ch.key_count),
  .out_key_word(out_ch.key_word), .out_last(out_ch.last)
);

FILE: tb/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// Checks the key list parser and alias lookup block.
// A short directed table covers empty and short lists, extreme characters,
// lookups on an empty table and ignored items. Random key lists follow, most
// of them well formed and some corrupted. Each list is followed by lookups.
// Each result is checked against the in-bench parser model or a directed row.
// ---------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import klp_pkg::*;

  localparam int KEY_CHARS   = (KEY_BYTES_DEF * 8 + 5) / 6;
  localparam int KEY_FIELD   = (KEY_CHARS + 3) / 4 * 4;
  localparam int ALIAS_FIELD = ALIAS_ASCII_BYTES_DEF
                               + (ALIAS_BYTES_DEF - ALIAS_ASCII_BYTES_DEF) * 2;
  localparam int RECORD_LEN  = KEY_FIELD + 1 + ALIAS_FIELD;
  localparam int KEY_WORDS   = (KEY_BYTES_DEF + 7) / 8;
  localparam int STALL_LIMIT = 5000;

  typedef struct {
    logic [1:0]  status;
    logic [4:0]  key_count;
    logic [63:0] key_word;
    logic        last;
  } result_t;

  typedef struct {
    kind_t       kind;
    logic [7:0]  list_char;
    logic [31:0] alias_high;
    logic [63:0] alias_low;
    bit          typed;
    status_t     status;
    logic [4:0]  key_count;
  } row_t;

  logic clk = 1'b0;
  logic rst_n;
  klp_in_if  in_ch ();
  klp_out_if out_ch ();

  key_list_parser_and_lookup_top u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Parser model state
  logic [63:0] key_mem [64];
  logic [31:0] alias_hi_mem [16];
  logic [63:0] alias_lo_mem [16];
  int unsigned keys_live, recs_done, chars_seen, field_pos;
  logic [11:0] bits_held;
  logic [63:0] word_acc;
  bit          bad_syntax;

  result_t expected_q[$];
  result_t fresh_q[$];
  int errors, n_items, n_results, n_hits, n_lists, n_rejects;
  int stall_cycles;
  bit quiet;
  logic [7:0] prev_alias [ALIAS_FIELD];

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int b64_decode(input logic [7:0] c);
    if (c >= "A" && c <= "Z") return c - "A";
    if (c >= "a" && c <= "z") return c - "a" + 26;
    if (c >= "0" && c <= "9") return c - "0" + 52;
    if (c == CH_PLUS) return 62;
    if (c == CH_SLASH) return 63;
    return -1;
  endfunction

  function automatic int hex_decode(input logic [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "a" && c <= "f") return c - "a" + 10;
    if (c >= "A" && c <= "F") return c - "A" + 10;
    return -1;
  endfunction

  function automatic void store_key_byte(input int unsigned rec, input int unsigned b,
                                         input logic [7:0] val);
    if (b >= KEY_BYTES_DEF) return;
    word_acc |= 64'(val) << (56 - 8 * (b % 8));
    if (b % 8 == 7 || b == KEY_BYTES_DEF - 1) begin
      key_mem[(rec * 4 + b / 8) & 63] = word_acc;
      word_acc = '0;
    end
  endfunction

  function automatic void store_alias_byte(input int unsigned rec, input int unsigned j,
                                           input logic [7:0] val);
    if (j >= ALIAS_BYTES_DEF || j >= 12) return;
    if (j < 4) alias_hi_mem[rec & 15][31 - 8 * j -: 8] = val;
    else alias_lo_mem[rec & 15][63 - 8 * (j - 4) -: 8] = val;
  endfunction

  function automatic void parse_char(input logic [7:0] c);
    int unsigned pos, rec, done, held, q, h;
    int v;
    pos = field_pos;
    rec = recs_done;
    if (chars_seen == 0) keys_live = 0;
    if (chars_seen < CHAR_TOTAL_MAX) chars_seen++;
    if (bad_syntax) return;
    if (pos >= RECORD_LEN) begin
      if (c == CH_SLASH) field_pos = 0;
      else bad_syntax = 1;
      return;
    end
    if (pos == 0 && rec >= MAX_KEYS_DEF) begin
      bad_syntax = 1;
      return;
    end
    if (pos < KEY_CHARS) begin
      v = b64_decode(c);
      if (v < 0) begin
        bad_syntax = 1;
        return;
      end
      if (pos == 0) begin
        bits_held = '0;
        word_acc = '0;
      end
      bits_held = {bits_held[5:0], 6'(v)};
      done = (pos * 6) / 8;
      held = (pos + 1) * 6 - 8 * done;
      if (held >= 8) store_key_byte(rec, done, 8'(bits_held >> (held - 8)));
    end else if (pos < KEY_FIELD) begin
      if (c != CH_EQUAL) begin
        bad_syntax = 1;
        return;
      end
    end else if (pos == KEY_FIELD) begin
      if (c != CH_COLON) begin
        bad_syntax = 1;
        return;
      end
      alias_hi_mem[rec & 15] = '0;
      alias_lo_mem[rec & 15] = '0;
    end else begin
      q = pos - KEY_FIELD - 1;
      if (q < ALIAS_ASCII_BYTES_DEF) begin
        if (c < 8'h20 || c > 8'h7E) begin
          bad_syntax = 1;
          return;
        end
        store_alias_byte(rec, q, c);
      end else begin
        h = q - ALIAS_ASCII_BYTES_DEF;
        v = hex_decode(c);
        if (v < 0) begin
          bad_syntax = 1;
          return;
        end
        if (h[0] == 1'b0) bits_held = 12'(v);
        else store_alias_byte(rec, ALIAS_ASCII_BYTES_DEF + h / 2, {bits_held[3:0], 4'(v)});
      end
    end
    field_pos = pos + 1;
    if (pos + 1 == RECORD_LEN) recs_done = rec + 1;
  endfunction

  // Work out the results of one accepted beat into fresh_q.
  function automatic void parse_and_lookup(input logic [1:0] kind, input logic [7:0] c,
                                           input logic [31:0] ah, input logic [63:0] al);
    result_t r;
    fresh_q.delete();
    if (kind == KIND_CHAR) begin
      parse_char(c);
    end else if (kind == KIND_END) begin
      r = '{ST_ACCEPTED, 5'd0, 64'd0, 1'b1};
      if (chars_seen < RECORD_LEN) r.key_count = 0;
      else if (bad_syntax || field_pos != RECORD_LEN) r.status = ST_SYNTAX;
      else r.key_count = 5'(recs_done);
      keys_live = r.key_count;
      recs_done = 0;
      chars_seen = 0;
      field_pos = 0;
      bits_held = '0;
      word_acc = '0;
      bad_syntax = 0;
      fresh_q.push_back(r);
    end else if (kind == KIND_LOOKUP) begin
      for (int i = 0; i < keys_live && i < MAX_KEYS_DEF; i++) begin
        if (alias_hi_mem[i] == ah && alias_lo_mem[i] == al) begin
          for (int w = 0; w < KEY_WORDS; w++) begin
            fresh_q.push_back('{ST_KEY_WORD, 5'd0, key_mem[(i * 4 + w) & 63],
                                w + 1 == KEY_WORDS});
          end
          return;
        end
      end
      fresh_q.push_back('{ST_NOT_FOUND, 5'd0, 64'd0, 1'b1});
    end
  endfunction

  task automatic drive_beat(input logic [1:0] kind, input logic [7:0] c,
                            input logic [31:0] ah, input logic [63:0] al,
                            input bit typed = 0, input result_t typed_res = '{0, 0, 0, 0});
    if (!quiet && $urandom_range(0, 99) < 10) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.kind       <= kind;
    in_ch.list_char  <= c;
    in_ch.alias_high <= ah;
    in_ch.alias_low  <= al;
    do @(posedge clk); while (!in_ch.ready);
    parse_and_lookup(kind, c, ah, al);
    if (typed) fresh_q = '{typed_res};
    foreach (fresh_q[i]) expected_q.push_back(fresh_q[i]);
    if (kind == KIND_LOOKUP && fresh_q[0].status == ST_KEY_WORD) n_hits++;
    if (kind == KIND_END) begin
      n_lists++;
      if (fresh_q[0].status == ST_SYNTAX) n_rejects++;
    end
    if (kind != KIND_NONE) n_items++;
  endtask

  function automatic logic [7:0] pick_b64();
    int v;
    v = $urandom_range(0, 63);
    if (v < 26) return 8'("A" + v);
    if (v < 52) return 8'("a" + v - 26);
    if (v < 62) return 8'("0" + v - 52);
    return v == 62 ? CH_PLUS : CH_SLASH;
  endfunction

  function automatic logic [7:0] pick_hex();
    int v;
    v = $urandom_range(0, 15);
    if (v < 10) return 8'("0" + v);
    return $urandom_range(0, 1) ? 8'("a" + v - 10) : 8'("A" + v - 10);
  endfunction

  function automatic void add_record(ref logic [7:0] text[$]);
    for (int i = 0; i < KEY_CHARS; i++) text.push_back(pick_b64());
    repeat (KEY_FIELD - KEY_CHARS) text.push_back(CH_EQUAL);
    text.push_back(CH_COLON);
    // Reuse the previous alias now and then so that first match matters.
    if ($urandom_range(0, 99) >= 15) begin
      for (int i = 0; i < ALIAS_FIELD; i++)
        prev_alias[i] = i < ALIAS_ASCII_BYTES_DEF ? 8'($urandom_range(8'h20, 8'h7E))
                                                  : pick_hex();
    end
    foreach (prev_alias[i]) text.push_back(prev_alias[i]);
  endfunction

  task automatic send_list(input int recs, input int damage, input int pad_to);
    logic [7:0] text[$];
    int p;
    for (int r = 0; r < recs; r++) begin
      if (r > 0) text.push_back(CH_SLASH);
      add_record(text);
    end
    p = $urandom_range(0, text.size() - 1);
    case (damage)
      1: text[p] = 8'($urandom_range(0, 255));
      2: text.delete(p);
      3: text.insert(p, pick_b64());
      4: text.push_back(CH_SLASH);
      5: begin
        text.push_back(CH_SLASH);
        text.push_back(CH_SLASH);
      end
      default: ;
    endcase
    while (text.size() < pad_to) text.push_back(8'($urandom_range(0, 255)));
    foreach (text[i]) begin
      drive_beat(KIND_CHAR, text[i], 32'd0, 64'd0);
      // Probe the table mid-list: it must already be empty.
      if ($urandom_range(0, 299) == 0)
        drive_beat(KIND_LOOKUP, 8'd0, $urandom, {$urandom, $urandom});
    end
    drive_beat(KIND_END, 8'd0, 32'd0, 64'd0);
  endtask

  task automatic probe_table(input int count);
    logic [31:0] ah;
    logic [63:0] al;
    int i;
    repeat (count) begin
      ah = $urandom;
      al = {$urandom, $urandom};
      if (keys_live > 0 && $urandom_range(0, 99) < 75) begin
        i = $urandom_range(0, keys_live - 1);
        ah = alias_hi_mem[i];
        al = alias_lo_mem[i];
        if ($urandom_range(0, 3) == 0) al[$urandom_range(0, 63)] ^= 1'b1;
      end
      drive_beat(KIND_LOOKUP, 8'($urandom), ah, al);
    end
  endtask

  row_t directed [] = '{
    '{KIND_END,    8'h00, 32'h0,        64'h0,                  1, ST_ACCEPTED,  5'd0},
    '{KIND_LOOKUP, 8'h00, 32'h0,        64'h0,                  1, ST_NOT_FOUND, 5'd0},
    '{KIND_LOOKUP, 8'hFF, 32'hFFFFFFFF, 64'hFFFFFFFFFFFFFFFF,   1, ST_NOT_FOUND, 5'd0},
    '{KIND_NONE,   8'hFF, 32'hFFFFFFFF, 64'hFFFFFFFFFFFFFFFF,   0, ST_ACCEPTED,  5'd0},
    '{KIND_CHAR,   8'h00, 32'h0,        64'h0,                  0, ST_ACCEPTED,  5'd0},
    '{KIND_CHAR,   8'hFF, 32'h0,        64'h0,                  0, ST_ACCEPTED,  5'd0},
    '{KIND_CHAR,   CH_EQUAL, 32'h0,     64'h0,                  0, ST_ACCEPTED,  5'd0},
    '{KIND_LOOKUP, 8'h00, 32'h12345678, 64'h0123456789ABCDEF,   1, ST_NOT_FOUND, 5'd0},
    '{KIND_CHAR,   CH_COLON, 32'h0,     64'h0,                  0, ST_ACCEPTED,  5'd0},
    '{KIND_CHAR,   CH_SLASH, 32'h0,     64'h0,                  0, ST_ACCEPTED,  5'd0},
    '{KIND_CHAR,   CH_PLUS,  32'h0,     64'h0,                  0, ST_ACCEPTED,  5'd0},
    '{KIND_NONE,   8'h41, 32'h0,        64'h0,                  0, ST_ACCEPTED,  5'd0},
    '{KIND_END,    8'h00, 32'h0,        64'h0,                  1, ST_ACCEPTED,  5'd0},
    '{KIND_END,    8'h00, 32'h0,        64'h0,                  1, ST_ACCEPTED,  5'd0},
    '{KIND_LOOKUP, 8'h00, 32'h0,        64'h0,                  1, ST_NOT_FOUND, 5'd0}
  };

  // Result side: random back-pressure and checking against the oldest expectation
  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= quiet || $urandom_range(0, 99) >= 10;
      if (out_ch.valid && out_ch.ready) begin
        n_results++;
        if (expected_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result: status %0d word %h",
                                     out_ch.status, out_ch.key_word);
        end else begin
          want = expected_q.pop_front();
          if (out_ch.status !== want.status || out_ch.key_count !== want.key_count ||
              out_ch.key_word !== want.key_word || out_ch.last !== want.last) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: exp st %0d cnt %0d word %h last %0d, got st %0d cnt %0d word %h last %0d",
                       want.status, want.key_count, want.key_word, want.last,
                       out_ch.status, out_ch.key_count, out_ch.key_word, out_ch.last);
          end
        end
      end
    end
  end

  // Watchdog on beats in either direction
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    result_t typed_res;
    int round, mode;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.kind = KIND_NONE;
    in_ch.list_char = '0;
    in_ch.alias_high = '0;
    in_ch.alias_low = '0;
    quiet = 0;
    for (int i = 0; i < 64; i++) key_mem[i] = '0;
    for (int i = 0; i < 16; i++) begin
      alias_hi_mem[i] = '0;
      alias_lo_mem[i] = '0;
    end
    keys_live = 0; recs_done = 0; chars_seen = 0; field_pos = 0;
    bits_held = '0; word_acc = '0; bad_syntax = 0;
    foreach (prev_alias[i]) prev_alias[i] = "0";
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      typed_res = '{directed[i].status, directed[i].key_count, 64'd0, 1'b1};
      drive_beat(directed[i].kind, directed[i].list_char, directed[i].alias_high,
                 directed[i].alias_low, directed[i].typed, typed_res);
    end

    round = 0;
    while (n_items < 360) begin
      quiet = (round % 6 == 3);
      mode = $urandom_range(0, 99);
      if (mode < 8) begin
        repeat ($urandom_range(0, 12)) begin
          if ($urandom_range(0, 9) == 0)
            drive_beat(KIND_NONE, 8'($urandom), $urandom, 64'd0);
          else drive_beat(KIND_CHAR, 8'($urandom), 32'd0, 64'd0);
        end
        drive_beat(KIND_END, 8'd0, 32'd0, 64'd0);
      end else begin
        send_list($urandom_range(1, 2), mode < 30 ? $urandom_range(1, 5) : 0, 0);
      end
      probe_table($urandom_range(1, 4));
      round++;
    end
    in_ch.valid <= 1'b0;

    while (expected_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("covered %0d lists (%0d rejected), %0d input beats, %0d results, %0d key hits",
             n_lists, n_rejects, n_items, n_results, n_hits);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d errors", errors);
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: files.f
design/klp_pkg.sv
design/klp_in_if.sv
design/klp_out_if.sv
design/klp_ram.sv
design/klp_front.sv
design/klp_queue.sv
design/klp_back.sv
design/key_list_parser_and_lookup_top.sv
design/klp_checker.sv
tb/testbench.sv
